// ===== rtl/core/usd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; used by every module of the decoder by scoped names.
`default_nettype none

package usd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CP_W        = 21;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned REP_W       = 2;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Sequence lengths held in the front state.
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // At most one job per input byte: rep_count replacements, then an optional tail result.
    typedef struct packed {
        logic [REP_W-1:0] rep_count;
        logic             has_tail;
        logic [CP_W-1:0]  tail_cp;
        logic             tail_bad;
    } usd_job_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } usd_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/usd_front.sv =====
// Front end of the UTF-8 decoder: accepts bytes, tracks the open sequence,
// and turns each byte into a job for the queue. Depends on usd_pkg.
`default_nettype none

module usd_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [usd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  wire usd_pkg::usd_qstat_t        qstat,
    output logic                            push,
    output usd_pkg::usd_job_t               push_job
);

    logic [2:0]                 seq_len_reg,  seq_len_next;
    logic [1:0]                 seen_reg,     seen_next;
    logic [usd_pkg::CP_W-1:0]   partial_reg,  partial_next;

    logic                       accept;
    logic                       seq_open;
    logic                       is_cont;
    logic [2:0]                 seen_inc;
    logic [usd_pkg::CP_W-1:0]   shifted;
    usd_pkg::usd_job_t          job;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign seq_open = (seq_len_reg != usd_pkg::SEQ_NONE);
    assign is_cont  = (s_tdata[7:6] == 2'b10);
    assign seen_inc = {1'b0, seen_reg} + 3'd1;
    assign shifted  = {partial_reg[usd_pkg::CP_W-7:0], s_tdata[5:0]};

    always_comb begin
        seq_len_next  = seq_len_reg;
        seen_next     = seen_reg;
        partial_next  = partial_reg;
        job.rep_count = '0;
        job.has_tail  = 1'b0;
        job.tail_cp   = usd_pkg::REPLACEMENT_CP;
        job.tail_bad  = 1'b0;

        if (seq_open && is_cont) begin
            partial_next = shifted;
            seen_next    = seen_inc[1:0];
            if ((seen_inc + 3'd1) >= seq_len_reg) begin
                job.has_tail = 1'b1;
                job.tail_cp  = shifted;
                seq_len_next = usd_pkg::SEQ_NONE;
                seen_next    = '0;
                partial_next = '0;
            end
        end else begin
            // broken sequence: flush lead plus accepted continuations
            if (seq_open) begin
                job.rep_count = seen_inc[1:0];
            end
            seq_len_next = usd_pkg::SEQ_NONE;
            seen_next    = '0;
            partial_next = '0;
            priority if (s_tdata == '0) begin
                // end of text, nothing of its own
            end else if (s_tdata[7] == 1'b0) begin
                job.has_tail = 1'b1;
                job.tail_cp  = {{(usd_pkg::CP_W-usd_pkg::BYTE_W){1'b0}}, s_tdata};
            end else if (s_tdata[7:5] == 3'b110) begin
                seq_len_next = usd_pkg::SEQ_TWO;
                partial_next = {{(usd_pkg::CP_W-5){1'b0}}, s_tdata[4:0]};
            end else if (s_tdata[7:4] == 4'b1110) begin
                seq_len_next = usd_pkg::SEQ_THREE;
                partial_next = {{(usd_pkg::CP_W-4){1'b0}}, s_tdata[3:0]};
            end else if (s_tdata[7:3] == 5'b11110) begin
                seq_len_next = usd_pkg::SEQ_FOUR;
                partial_next = {{(usd_pkg::CP_W-3){1'b0}}, s_tdata[2:0]};
            end else begin
                // stray continuation or F8..FF lead
                job.has_tail = 1'b1;
                job.tail_cp  = usd_pkg::REPLACEMENT_CP;
                job.tail_bad = 1'b1;
            end
        end
    end

    assign push     = accept && ((job.rep_count != '0) || job.has_tail);
    assign push_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg <= usd_pkg::SEQ_NONE;
            seen_reg    <= '0;
            partial_reg <= '0;
        end else if (accept) begin
            seq_len_reg <= seq_len_next;
            seen_reg    <= seen_next;
            partial_reg <= partial_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/usd_queue.sv =====
// Small job queue between the decoder front and back ends.
// Depends on usd_pkg for the job type and depth.
`default_nettype none

module usd_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire usd_pkg::usd_job_t    push_job,
    input  wire logic                 pop,
    output usd_pkg::usd_job_t         head_job,
    output usd_pkg::usd_qstat_t       qstat
);

    usd_pkg::usd_job_t               entry_reg [usd_pkg::QUEUE_DEPTH];
    logic [usd_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [usd_pkg::QCNT_W-1:0]      count_reg,  count_next;

    assign qstat.full  = (count_reg == usd_pkg::QCNT_W'(usd_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_job    = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/usd_back.sv =====
// Back end of the UTF-8 decoder: expands each queued job into its results
// and holds them in the output register. Depends on usd_pkg.
`default_nettype none

module usd_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire usd_pkg::usd_job_t               head_job,
    input  wire usd_pkg::usd_qstat_t             qstat,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [usd_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);

    logic [usd_pkg::REP_W-1:0]   idx_reg;
    logic                        valid_reg;
    logic [usd_pkg::CP_W-1:0]    cp_reg;
    logic                        bad_reg;
    logic                        last_reg;

    logic                        out_free;
    logic                        advance;
    logic [usd_pkg::REP_W:0]     total;
    logic                        is_rep;
    logic                        is_last;
    logic [usd_pkg::CP_W-1:0]    cur_cp;
    logic                        cur_bad;

    assign out_free = !valid_reg || m_tready;
    assign advance  = out_free && !qstat.empty;
    assign total    = {1'b0, head_job.rep_count} + {{usd_pkg::REP_W{1'b0}}, head_job.has_tail};
    assign is_rep   = (idx_reg < head_job.rep_count);
    assign is_last  = ({1'b0, idx_reg} + 1'b1) == total;
    assign cur_cp   = is_rep ? usd_pkg::REPLACEMENT_CP : head_job.tail_cp;
    assign cur_bad  = is_rep ? 1'b1 : head_job.tail_bad;
    assign pop      = advance && is_last;

    always_ff @(posedge aclk) begin
        if (advance) begin
            cp_reg   <= cur_cp;
            bad_reg  <= cur_bad;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (out_free) valid_reg <= !qstat.empty;
            if (advance) idx_reg <= is_last ? '0 : idx_reg + 1'b1;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(usd_pkg::OUT_TDATA_W-usd_pkg::CP_W-1){1'b0}}, bad_reg, cp_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder, top level; instantiates usd_front, usd_queue, usd_back (usd_pkg).
// A taken byte's job is written into the job queue, and the back end moves its results
// into the output register. Throughput: one byte per cycle while each byte yields at most
// one result and the receiver keeps up; a byte that yields more results (broken sequence,
// up to four) holds the back end, and the four-entry job queue absorbs the burst. Reset:
// aresetn, synchronous, active low; clears the open sequence, the queue and the output valid.
`default_nettype none

module utf8_stream_decoder_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input byte requests
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [usd_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] in_byte
    // decoded result requests
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [usd_pkg::OUT_TDATA_W-1:0]       m_tdata,   // [20:0] code_point, [21] malformed
    output logic                                  m_tlast    // last_of_run
);

    // Front classifies each byte into a job: replacements to flush plus an
    // optional tail (ASCII, completed code point, or a lone U+FFFD).
    usd_pkg::usd_qstat_t qstat;
    usd_pkg::usd_job_t   push_job;
    usd_pkg::usd_job_t   head_job;
    logic                push;
    logic                pop;

    usd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .qstat    (qstat),
        .push     (push),
        .push_job (push_job)
    );

    // Jobs wait here so a multi-result byte does not stall the input side.
    usd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    // Back walks one result per cycle out of the head job while its output register is free;
    // the job is popped together with its last result.
    usd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/usd_result_checker.sv =====
// Result checker for the UTF-8 stream decoder: watches the byte and result request
// channels, decodes every accepted byte on its own and compares each result request.
// Depends on usd_pkg (widths, sequence lengths, replacement code point).
module usd_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [usd_pkg::BYTE_W-1:0]     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [usd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             waiting_count
);

    typedef struct packed {
        logic [usd_pkg::CP_W-1:0] code_point;
        logic                     malformed;
        logic                     last_of_run;
    } cp_result_t;

    cp_result_t               expected_cps[$];
    logic [2:0]               open_len;
    logic [1:0]               conts_seen;
    logic [usd_pkg::CP_W-1:0] gathered_cp;
    int                       fails;

    function automatic cp_result_t make_result(input logic [usd_pkg::CP_W-1:0] cp,
                                               input logic bad);
        cp_result_t r;
        r.code_point  = cp;
        r.malformed   = bad;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    task automatic close_sequence();
        open_len    = usd_pkg::SEQ_NONE;
        conts_seen  = 2'd0;
        gathered_cp = '0;
    endtask

    // Decode one byte and queue the code points it causes, last one flagged.
    task automatic decode_byte(input logic [7:0] b);
        cp_result_t run[$];
        cp_result_t r;
        bit         consumed;
        consumed = 1'b0;
        if (open_len != usd_pkg::SEQ_NONE) begin
            if (b[7:6] == 2'b10) begin
                gathered_cp = {gathered_cp[usd_pkg::CP_W-7:0], b[5:0]};
                conts_seen  = conts_seen + 2'd1;
                if ({1'b0, conts_seen} + 3'd1 >= open_len) begin
                    run.push_back(make_result(gathered_cp, 1'b0));
                    close_sequence();
                end
                consumed = 1'b1;
            end else begin
                // broken sequence: one replacement for the lead and each continuation
                for (int i = 0; i <= conts_seen; i++)
                    run.push_back(make_result(usd_pkg::REPLACEMENT_CP, 1'b1));
                close_sequence();
            end
        end
        if (!consumed) begin
            casez (b)
                8'h00: close_sequence();
                8'b0???_????: run.push_back(make_result(usd_pkg::CP_W'(b), 1'b0));
                8'b110?_????: begin
                    open_len    = usd_pkg::SEQ_TWO;
                    gathered_cp = usd_pkg::CP_W'(b[4:0]);
                end
                8'b1110_????: begin
                    open_len    = usd_pkg::SEQ_THREE;
                    gathered_cp = usd_pkg::CP_W'(b[3:0]);
                end
                8'b1111_0???: begin
                    open_len    = usd_pkg::SEQ_FOUR;
                    gathered_cp = usd_pkg::CP_W'(b[2:0]);
                end
                default: run.push_back(make_result(usd_pkg::REPLACEMENT_CP, 1'b1));
            endcase
        end
        foreach (run[i]) begin
            r = run[i];
            r.last_of_run = (i == run.size() - 1);
            expected_cps.push_back(r);
        end
    endtask

    task automatic compare_result();
        cp_result_t want;
        if (expected_cps.size() == 0) begin
            fails++;
            $display("%0t: unexpected result cp=%h malformed=%b last=%b", $time,
                     m_tdata[usd_pkg::CP_W-1:0], m_tdata[usd_pkg::CP_W], m_tlast);
        end else begin
            want = expected_cps.pop_front();
            if (m_tdata[usd_pkg::CP_W-1:0] !== want.code_point) begin
                fails++;
                $display("%0t: code_point expected %h actual %h", $time,
                         want.code_point, m_tdata[usd_pkg::CP_W-1:0]);
            end
            if (m_tdata[usd_pkg::CP_W] !== want.malformed) begin
                fails++;
                $display("%0t: malformed expected %b actual %b", $time,
                         want.malformed, m_tdata[usd_pkg::CP_W]);
            end
            if (m_tlast !== want.last_of_run) begin
                fails++;
                $display("%0t: last_of_run expected %b actual %b", $time,
                         want.last_of_run, m_tlast);
            end
        end
    endtask

    initial begin
        fails = 0;
        close_sequence();
    end

    // Results leave only after their byte is taken, so results are compared first.
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_cps.delete();
            close_sequence();
        end else begin
            if (m_tvalid && m_tready)
                compare_result();
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
        end
        fail_count    <= fails;
        waiting_count <= expected_cps.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the UTF-8 stream decoder bench: clock, reset, byte stimulus and receiver stalls.
// Depends on usd_pkg, utf8_stream_decoder_unit and usd_result_checker.
module tb_top;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [usd_pkg::BYTE_W-1:0]      s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [usd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    int fail_count;
    int waiting_count;

    int bytes_sent   = 0;
    int burst_left   = 0;
    bit calm_sender  = 1'b0;  // no gaps between byte requests while set
    int hold_asks    = 0;     // long receiver hold-offs requested by stimulus
    int holds_done   = 0;

    // Directed text: lone NUL, ASCII, overlong zero, top code point, genuine U+FFFD,
    // stray continuation, invalid lead, two broken sequences, a flushed sequence.
    logic [7:0] intro_text [25] = '{
        8'h00,
        8'h41,
        8'hC0, 8'h80,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'hEF, 8'hBF, 8'hBD,
        8'h80,
        8'hFF,
        8'hE2, 8'h82, 8'h7F,
        8'hF0, 8'h9F, 8'h98, 8'hC3, 8'hA9,
        8'hF0, 8'h80, 8'h80, 8'h00
    };

    utf8_stream_decoder_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    usd_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .waiting_count (waiting_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the decoder hangs.
    initial begin
        #2400000;
        $display("FAILURE");
        $finish;
    end

    // Offer one byte request and hold it until taken; then maybe idle for a gap
    // once the current burst is used up.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        if (!calm_sender) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Lead of a len-byte sequence with random payload, followed by continuations;
    // only the first n_bytes of the sequence go out.
    task automatic send_sequence(input int len, input int n_bytes);
        logic [7:0] lead;
        logic [7:0] rnd;
        rnd = 8'($urandom_range(0, 255));
        case (len)
            2: begin
                lead = {3'b110, rnd[4:0]};
            end
            3: begin
                lead = {4'b1110, rnd[3:0]};
            end
            default: begin
                lead = {5'b11110, rnd[2:0]};
            end
        endcase
        push_byte(lead);
        for (int k = 1; k < n_bytes; k++) begin
            rnd = 8'($urandom_range(0, 63));
            push_byte({2'b10, rnd[5:0]});
        end
    endtask

    // Receiver: switches among stall styles at random; on request it holds off
    // for a long stretch so the job queue fills and the input stalls.
    initial begin
        int unsigned style;
        int unsigned cyc;
        style = 0;
        cyc   = 0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_asks) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (90) @(posedge aclk);
            end else begin
                if (cyc % 48 == 0)
                    style = $urandom_range(0, 3);
                cyc++;
                case (style)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 1) != 0);
                    end
                    default: begin
                        m_tready <= (cyc % 8 < 5);
                    end
                endcase
            end
        end
    end

    initial begin
        int         pick;
        int         len;
        logic [7:0] rnd;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (intro_text[i])
            push_byte(intro_text[i]);

        while (bytes_sent < 420) begin
            // long hold-offs: once early, once midway; sender runs without gaps
            if ((hold_asks == 0) || (hold_asks == 1 && bytes_sent >= 250)) begin
                hold_asks <= hold_asks + 1;
                calm_sender = 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
                calm_sender = !calm_sender;
            end

            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                rnd = 8'($urandom_range(1, 127));
                push_byte(rnd);
            end else if (pick < 62) begin
                len = $urandom_range(2, 4);
                send_sequence(len, len);
            end else if (pick < 68) begin
                push_byte(8'h00);
            end else if (pick < 84) begin
                // cut-off sequence followed by an arbitrary byte
                len = $urandom_range(2, 4);
                send_sequence(len, $urandom_range(1, len - 1));
                rnd = 8'($urandom_range(0, 255));
                push_byte(rnd);
            end else begin
                rnd = 8'($urandom_range(0, 255));
                push_byte(rnd);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (waiting_count != 0) @(posedge aclk);
        // catch any stray result after the last expected one
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/usd_pkg.sv
rtl/core/usd_front.sv
rtl/core/usd_queue.sv
rtl/core/usd_back.sv
rtl/core/utf8_stream_decoder_unit.sv
bench/usd_result_checker.sv
bench/tb_top.sv
